FILE: rtl/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants of the readers-writer lock arbiter.
// ----------------------------------------------------------------------------
package rwl_pkg;

    localparam int READER_QUEUE_DEPTH = 16;
    localparam int WRITER_QUEUE_DEPTH = 16;
    localparam int ID_BITS            = 8;

    localparam int REQ_TYPE_W = 2;
    localparam int ID_W       = 8;
    localparam int READERS_W  = 8;

    localparam int RQ_AW    = (READER_QUEUE_DEPTH > 1) ? $clog2(READER_QUEUE_DEPTH) : 1;
    localparam int WQ_AW    = (WRITER_QUEUE_DEPTH > 1) ? $clog2(WRITER_QUEUE_DEPTH) : 1;
    localparam int RQ_CNT_W = $clog2(READER_QUEUE_DEPTH + 1);
    localparam int WQ_CNT_W = $clog2(WRITER_QUEUE_DEPTH + 1);

    localparam logic [READERS_W-1:0] READERS_MAX = 8'd255;

    localparam logic STATUS_GRANTED  = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;
    localparam logic ACCESS_READ     = 1'b0;
    localparam logic ACCESS_WRITE    = 1'b1;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_READ_ACQ  = 2'd0,
        REQ_READ_REL  = 2'd1,
        REQ_WRITE_ACQ = 2'd2,
        REQ_WRITE_REL = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/rwl_req_if.sv
// ----------------------------------------------------------------------------
// rwl_req_if
// Lock request channel: valid/ready handshake with request type and id.
// ----------------------------------------------------------------------------
interface rwl_req_if;
    logic                           valid;
    logic                           ready;
    logic [rwl_pkg::REQ_TYPE_W-1:0] req_type;
    logic [rwl_pkg::ID_W-1:0]       requester_id;

    modport source (output valid, output req_type, output requester_id, input ready);
    modport sink   (input valid, input req_type, input requester_id, output ready);
endinterface

FILE: rtl/rwl_grant_if.sv
// ----------------------------------------------------------------------------
// rwl_grant_if
// Grant channel: valid/ready handshake with grant or reject result.
// ----------------------------------------------------------------------------
interface rwl_grant_if;
    logic                     valid;
    logic                     ready;
    logic [rwl_pkg::ID_W-1:0] grant_id;
    logic                     grant_is_writer;
    logic                     status;
    logic                     last;

    modport source (output valid, output grant_id, output grant_is_writer,
                    output status, output last, input ready);
    modport sink   (input valid, input grant_id, input grant_is_writer,
                    input status, input last, output ready);
endinterface

FILE: rtl/readers_writer_lock_arbiter.sv
// ----------------------------------------------------------------------------
// readers_writer_lock_arbiter
// Readers-writer lock with writer preference; waiting ids kept in two RAM FIFOs.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is first captured, then
// evaluated against the counters; each grant popped from a wait queue needs
// a queue RAM read and then a load of the output register. The single output
// register holds one result; evaluation waits while it is full and not being
// taken. The wait queues are two 16 x 8 RAMs whose entries are guarded by the
// wait counts, so no clearing pass follows reset.
module readers_writer_lock_arbiter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rwl_req_if.sink       i_req,
    rwl_grant_if.source   o_grant
);

    rwl_pkg::t_state    r_state, n_state;
    rwl_pkg::t_req_type r_req_type, n_req_type;
    logic [rwl_pkg::ID_BITS-1:0]   r_req_id, n_req_id;
    logic [rwl_pkg::READERS_W-1:0] r_active, n_active;
    logic                          r_wactive, n_wactive;
    logic [rwl_pkg::RQ_CNT_W-1:0]  r_rcnt, n_rcnt;
    logic [rwl_pkg::WQ_CNT_W-1:0]  r_wcnt, n_wcnt;
    logic [rwl_pkg::RQ_AW-1:0]     r_rhead, n_rhead;
    logic [rwl_pkg::WQ_AW-1:0]     r_whead, n_whead;
    logic                          r_pop_wr, n_pop_wr;

    logic                          r_out_valid, n_out_valid;
    logic [rwl_pkg::ID_W-1:0]      r_out_id, n_out_id;
    logic                          r_out_wr, n_out_wr;
    logic                          r_out_st, n_out_st;
    logic                          r_out_last, n_out_last;

    logic                          out_free;
    logic                          c_pop_rd_start;
    logic                          c_pop_wr_start;
    logic                          c_more;

    logic                          rq_we, wq_we;
    logic [rwl_pkg::RQ_AW-1:0]     rq_tail;
    logic [rwl_pkg::WQ_AW-1:0]     wq_tail;
    logic [rwl_pkg::ID_BITS-1:0]   rq_rdata, wq_rdata;
    logic [rwl_pkg::RQ_CNT_W:0]    rq_sum;
    logic [rwl_pkg::WQ_CNT_W:0]    wq_sum;

    // queue tails: (head + count) mod depth
    assign rq_sum  = (rwl_pkg::RQ_CNT_W + 1)'(r_rhead) + (rwl_pkg::RQ_CNT_W + 1)'(r_rcnt);
    assign wq_sum  = (rwl_pkg::WQ_CNT_W + 1)'(r_whead) + (rwl_pkg::WQ_CNT_W + 1)'(r_wcnt);
    assign rq_tail = (rq_sum >= (rwl_pkg::RQ_CNT_W + 1)'(rwl_pkg::READER_QUEUE_DEPTH))
                   ? rwl_pkg::RQ_AW'(rq_sum - (rwl_pkg::RQ_CNT_W + 1)'(rwl_pkg::READER_QUEUE_DEPTH))
                   : rwl_pkg::RQ_AW'(rq_sum);
    assign wq_tail = (wq_sum >= (rwl_pkg::WQ_CNT_W + 1)'(rwl_pkg::WRITER_QUEUE_DEPTH))
                   ? rwl_pkg::WQ_AW'(wq_sum - (rwl_pkg::WQ_CNT_W + 1)'(rwl_pkg::WRITER_QUEUE_DEPTH))
                   : rwl_pkg::WQ_AW'(wq_sum);

    rwl_ram #(
        .WIDTH (rwl_pkg::ID_BITS),
        .DEPTH (rwl_pkg::READER_QUEUE_DEPTH)
    ) u_reader_queue (
        .i_clk   (i_clk),
        .i_we    (rq_we),
        .i_waddr (rq_tail),
        .i_wdata (r_req_id),
        .i_raddr (r_rhead),
        .o_rdata (rq_rdata)
    );

    rwl_ram #(
        .WIDTH (rwl_pkg::ID_BITS),
        .DEPTH (rwl_pkg::WRITER_QUEUE_DEPTH)
    ) u_writer_queue (
        .i_clk   (i_clk),
        .i_we    (wq_we),
        .i_waddr (wq_tail),
        .i_wdata (r_req_id),
        .i_raddr (r_whead),
        .o_rdata (wq_rdata)
    );

    assign out_free = !r_out_valid || o_grant.ready;

    assign c_pop_rd_start = (r_req_type == rwl_pkg::REQ_WRITE_REL) && r_wactive &&
                            (r_rcnt != '0) && (r_active != rwl_pkg::READERS_MAX);
    assign c_pop_wr_start = ((r_req_type == rwl_pkg::REQ_READ_REL) &&
                             (r_active == rwl_pkg::READERS_W'(1)) &&
                             (r_wcnt != '0) && !r_wactive) ||
                            ((r_req_type == rwl_pkg::REQ_WRITE_REL) && r_wactive &&
                             (r_rcnt == '0) && (r_wcnt != '0));
    assign c_more = !r_pop_wr && (r_rcnt != rwl_pkg::RQ_CNT_W'(1)) &&
                    (r_active != rwl_pkg::READERS_MAX - rwl_pkg::READERS_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwl_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = rwl_pkg::ST_EVAL;
                end
            end
            rwl_pkg::ST_EVAL: begin
                if (out_free) begin
                    n_state = (c_pop_rd_start || c_pop_wr_start) ? rwl_pkg::ST_READ
                                                                 : rwl_pkg::ST_IDLE;
                end
            end
            rwl_pkg::ST_READ: begin
                n_state = rwl_pkg::ST_EMIT;
            end
            rwl_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = c_more ? rwl_pkg::ST_READ : rwl_pkg::ST_IDLE;
                end
            end
            default: n_state = rwl_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req_type  = r_req_type;
        n_req_id    = r_req_id;
        n_active    = r_active;
        n_wactive   = r_wactive;
        n_rcnt      = r_rcnt;
        n_wcnt      = r_wcnt;
        n_rhead     = r_rhead;
        n_whead     = r_whead;
        n_pop_wr    = r_pop_wr;
        n_out_valid = r_out_valid && !o_grant.ready;
        n_out_id    = r_out_id;
        n_out_wr    = r_out_wr;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        rq_we       = 1'b0;
        wq_we       = 1'b0;
        i_req.ready = 1'b0;

        unique case (r_state)
            rwl_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_req_type = rwl_pkg::t_req_type'(i_req.req_type);
                    n_req_id   = i_req.requester_id[rwl_pkg::ID_BITS-1:0];
                end
            end
            rwl_pkg::ST_EVAL: begin
                if (out_free) begin
                    n_out_id   = rwl_pkg::ID_W'(r_req_id);
                    n_out_last = 1'b1;
                    n_pop_wr   = c_pop_wr_start;
                    case (r_req_type)
                        rwl_pkg::REQ_READ_ACQ: begin
                            n_out_wr = rwl_pkg::ACCESS_READ;
                            if (r_wactive || (r_wcnt != '0)) begin
                                if (r_rcnt == rwl_pkg::RQ_CNT_W'(rwl_pkg::READER_QUEUE_DEPTH)) begin
                                    n_out_valid = 1'b1;
                                    n_out_st    = rwl_pkg::STATUS_REJECTED;
                                end else begin
                                    rq_we  = 1'b1;
                                    n_rcnt = r_rcnt + rwl_pkg::RQ_CNT_W'(1);
                                end
                            end else if (r_active == rwl_pkg::READERS_MAX) begin
                                n_out_valid = 1'b1;
                                n_out_st    = rwl_pkg::STATUS_REJECTED;
                            end else begin
                                n_active    = r_active + rwl_pkg::READERS_W'(1);
                                n_out_valid = 1'b1;
                                n_out_st    = rwl_pkg::STATUS_GRANTED;
                            end
                        end
                        rwl_pkg::REQ_READ_REL: begin
                            if (r_active != '0) begin
                                n_active = r_active - rwl_pkg::READERS_W'(1);
                            end
                        end
                        rwl_pkg::REQ_WRITE_ACQ: begin
                            n_out_wr = rwl_pkg::ACCESS_WRITE;
                            if ((r_active != '0) || r_wactive) begin
                                if (r_wcnt == rwl_pkg::WQ_CNT_W'(rwl_pkg::WRITER_QUEUE_DEPTH)) begin
                                    n_out_valid = 1'b1;
                                    n_out_st    = rwl_pkg::STATUS_REJECTED;
                                end else begin
                                    wq_we  = 1'b1;
                                    n_wcnt = r_wcnt + rwl_pkg::WQ_CNT_W'(1);
                                end
                            end else begin
                                n_wactive   = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_st    = rwl_pkg::STATUS_GRANTED;
                            end
                        end
                        default: begin
                            n_wactive = 1'b0;
                        end
                    endcase
                end
            end
            rwl_pkg::ST_READ: begin
            end
            rwl_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = rwl_pkg::STATUS_GRANTED;
                    if (r_pop_wr) begin
                        n_out_id   = rwl_pkg::ID_W'(wq_rdata);
                        n_out_wr   = rwl_pkg::ACCESS_WRITE;
                        n_out_last = 1'b1;
                        n_wactive  = 1'b1;
                        n_wcnt     = r_wcnt - rwl_pkg::WQ_CNT_W'(1);
                        n_whead    = (r_whead == rwl_pkg::WQ_AW'(rwl_pkg::WRITER_QUEUE_DEPTH - 1))
                                   ? '0 : r_whead + rwl_pkg::WQ_AW'(1);
                    end else begin
                        n_out_id   = rwl_pkg::ID_W'(rq_rdata);
                        n_out_wr   = rwl_pkg::ACCESS_READ;
                        n_out_last = !c_more;
                        n_active   = r_active + rwl_pkg::READERS_W'(1);
                        n_rcnt     = r_rcnt - rwl_pkg::RQ_CNT_W'(1);
                        n_rhead    = (r_rhead == rwl_pkg::RQ_AW'(rwl_pkg::READER_QUEUE_DEPTH - 1))
                                   ? '0 : r_rhead + rwl_pkg::RQ_AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwl_pkg::ST_IDLE;
            r_active    <= '0;
            r_wactive   <= 1'b0;
            r_rcnt      <= '0;
            r_wcnt      <= '0;
            r_rhead     <= '0;
            r_whead     <= '0;
            r_pop_wr    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_wactive   <= n_wactive;
            r_rcnt      <= n_rcnt;
            r_wcnt      <= n_wcnt;
            r_rhead     <= n_rhead;
            r_whead     <= n_whead;
            r_pop_wr    <= n_pop_wr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_req_id   <= n_req_id;
        r_out_id   <= n_out_id;
        r_out_wr   <= n_out_wr;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_grant.valid           = r_out_valid;
    assign o_grant.grant_id        = r_out_id;
    assign o_grant.grant_is_writer = r_out_wr;
    assign o_grant.status          = r_out_st;
    assign o_grant.last            = r_out_last;

    // a writer never holds the lock together with readers
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wactive && (r_active != '0)))
        else $error("writer active while readers hold the lock");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rcnt <= rwl_pkg::RQ_CNT_W'(rwl_pkg::READER_QUEUE_DEPTH)) &&
        (r_wcnt <= rwl_pkg::WQ_CNT_W'(rwl_pkg::WRITER_QUEUE_DEPTH)))
        else $error("wait count beyond queue depth");

    // a pop only ever reads a queue that holds an entry
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rwl_pkg::ST_EMIT) |->
        (r_pop_wr ? (r_wcnt != '0) : ((r_rcnt != '0) && (r_active != rwl_pkg::READERS_MAX))))
        else $error("pop from empty wait queue");

endmodule

FILE: rtl/rwl_ram.sv
// ----------------------------------------------------------------------------
// rwl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
